FILE: design/cau_pkg.sv
// shared types for the complex arithmetic unit
// no dependencies
`default_nettype none

package cau_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4
    } op_t;

    // control that rides along with each word
    typedef struct packed {
        op_t  op;
        logic dz;
    } ctl_t;

endpackage

`default_nettype wire

FILE: design/cau_mult.sv
// first stage: all operand products and the add/subtract sums
// depends on cau_pkg
`default_nettype none

module cau_mult #(
    parameter int W = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  up_ld,
    input  logic                  down_ld,
    output logic                  out_valid,
    input  logic [2:0]            op_in,
    input  logic signed [W-1:0]   ar,
    input  logic signed [W-1:0]   ai,
    input  logic signed [W-1:0]   br,
    input  logic signed [W-1:0]   bi,
    output cau_pkg::ctl_t         ctl,
    output logic signed [2*W-1:0] m1,
    output logic signed [2*W-1:0] m2,
    output logic signed [2*W-1:0] m3,
    output logic signed [2*W-1:0] m4,
    output logic signed [2*W-1:0] m5,
    output logic signed [2*W-1:0] m6,
    output logic signed [W:0]     sum_r,
    output logic signed [W:0]     sum_i
);
    import cau_pkg::*;

    logic                  valid_reg;
    ctl_t                  ctl_reg, ctl_next;
    logic signed [W-1:0]   x1, x2;
    logic signed [2*W-1:0] m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;
    logic signed [2*W-1:0] m1_next, m2_next, m3_next, m4_next, m5_next, m6_next;
    logic signed [W:0]     sum_r_reg, sum_i_reg, sum_r_next, sum_i_next;

    assign up_ld = !valid_reg || down_ld;

    always_comb
    begin
        ctl_next.op = op_t'(op_in);
        ctl_next.dz = 1'b0;
        // modulus reuses the first two multipliers for the squares of a
        x1 = (ctl_next.op == OP_MOD) ? ar : br;
        x2 = (ctl_next.op == OP_MOD) ? ai : bi;
        m1_next = ar * x1;
        m2_next = ai * x2;
        m3_next = ar * bi;
        m4_next = ai * br;
        m5_next = br * br;
        m6_next = bi * bi;
        if (ctl_next.op == OP_SUB)
        begin
            sum_r_next = ar - br;
            sum_i_next = ai - bi;
        end
        else
        begin
            sum_r_next = ar + br;
            sum_i_next = ai + bi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ld)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ld)
        begin
            ctl_reg   <= ctl_next;
            m1_reg    <= m1_next;
            m2_reg    <= m2_next;
            m3_reg    <= m3_next;
            m4_reg    <= m4_next;
            m5_reg    <= m5_next;
            m6_reg    <= m6_next;
            sum_r_reg <= sum_r_next;
            sum_i_reg <= sum_i_next;
        end
    end

    assign out_valid = valid_reg;
    assign ctl       = ctl_reg;
    assign m1        = m1_reg;
    assign m2        = m2_reg;
    assign m3        = m3_reg;
    assign m4        = m4_reg;
    assign m5        = m5_reg;
    assign m6        = m6_reg;
    assign sum_r     = sum_r_reg;
    assign sum_i     = sum_i_reg;

endmodule

`default_nettype wire

FILE: design/cau_prep.sv
// three stages: numerators and divisor, sign/magnitude, divider setup
// depends on cau_pkg
`default_nettype none

module cau_prep #(
    parameter int W = 16,
    parameter int F = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        up_ld,
    input  logic                        down_ld,
    output logic                        out_valid,
    input  cau_pkg::ctl_t               ctl_in,
    input  logic signed [2*W-1:0]       m1,
    input  logic signed [2*W-1:0]       m2,
    input  logic signed [2*W-1:0]       m3,
    input  logic signed [2*W-1:0]       m4,
    input  logic signed [2*W-1:0]       m5,
    input  logic signed [2*W-1:0]       m6,
    input  logic signed [W:0]           sum_r,
    input  logic signed [W:0]           sum_i,
    output cau_pkg::ctl_t               ctl_out,
    output logic [2*W-1:0]              den,
    output logic [1:0]                  neg,
    output logic [1:0]                  ovf,
    output logic [1:0][2*W-1:0]         rem,
    output logic [1:0][W+F:0]           acc,
    output logic [2*W-1:0]              sqn,
    output logic [2*W-1:0]              sqr
);
    import cau_pkg::*;

    localparam int QB = W + F + 1;

    logic [2:0] valid_reg;
    logic [2:0] ld;

    // stage a
    ctl_t                ctl_a_reg;
    logic signed [2*W:0] num_r_reg, num_i_reg, num_r_next, num_i_next;
    logic [2*W-1:0]      den_a_reg, den_a_next;
    // stage b
    ctl_t                ctl_b_reg, ctl_b_next;
    logic [1:0]          neg_b_reg, neg_b_next;
    logic [1:0][2*W-1:0] mag_b_reg, mag_b_next;
    logic [2*W-1:0]      den_b_reg;
    // stage c
    ctl_t                ctl_c_reg;
    logic [2*W-1:0]      den_c_reg;
    logic [1:0]          neg_c_reg;
    logic [1:0]          ovf_c_reg, ovf_c_next;
    logic [1:0][2*W-1:0] rem_c_reg, rem_c_next;
    logic [1:0][QB-1:0]  acc_c_reg, acc_c_next;

    assign ld[2] = !valid_reg[2] || down_ld;
    assign ld[1] = !valid_reg[1] || ld[2];
    assign ld[0] = !valid_reg[0] || ld[1];
    assign up_ld = ld[0];

    always_comb
    begin
        den_a_next = (2*W)'(m5) + (2*W)'(m6);
        case (ctl_in.op)
            OP_ADD, OP_SUB:
            begin
                num_r_next = sum_r;
                num_i_next = sum_i;
            end
            OP_MUL:
            begin
                num_r_next = m1 - m2;
                num_i_next = m3 + m4;
            end
            OP_DIV:
            begin
                num_r_next = m1 + m2;
                num_i_next = m4 - m3;
            end
            OP_MOD:
            begin
                num_r_next = m1 + m2;
                num_i_next = '0;
            end
            default:
            begin
                num_r_next = '0;
                num_i_next = '0;
            end
        endcase
    end

    always_comb
    begin
        ctl_b_next    = ctl_a_reg;
        ctl_b_next.dz = (ctl_a_reg.op == OP_DIV) && (den_a_reg == '0);
        neg_b_next[0] = num_r_reg[2*W];
        neg_b_next[1] = num_i_reg[2*W];
        mag_b_next[0] = num_r_reg[2*W] ? (2*W)'(-num_r_reg) : num_r_reg[2*W-1:0];
        mag_b_next[1] = num_i_reg[2*W] ? (2*W)'(-num_i_reg) : num_i_reg[2*W-1:0];
    end

    // integer quotient of 2^W or more can only saturate; otherwise the
    // partial remainder of a division starts with the upper half of the numerator
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            ovf_c_next[l] = {{W{1'b0}}, mag_b_reg[l][2*W-1:W]} >= den_b_reg;
            rem_c_next[l] = (ctl_b_reg.op == OP_DIV) ?
                            {{W{1'b0}}, mag_b_reg[l][2*W-1:W]} : mag_b_reg[l];
            acc_c_next[l] = {mag_b_reg[l][W-1:0], {(F+1){1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (ld[0])
                valid_reg[0] <= in_valid;
            if (ld[1])
                valid_reg[1] <= valid_reg[0];
            if (ld[2])
                valid_reg[2] <= valid_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            ctl_a_reg <= ctl_in;
            num_r_reg <= num_r_next;
            num_i_reg <= num_i_next;
            den_a_reg <= den_a_next;
        end
        if (ld[1])
        begin
            ctl_b_reg <= ctl_b_next;
            neg_b_reg <= neg_b_next;
            mag_b_reg <= mag_b_next;
            den_b_reg <= den_a_reg;
        end
        if (ld[2])
        begin
            ctl_c_reg <= ctl_b_reg;
            den_c_reg <= den_b_reg;
            neg_c_reg <= neg_b_reg;
            ovf_c_reg <= ovf_c_next;
            rem_c_reg <= rem_c_next;
            acc_c_reg <= acc_c_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign ctl_out   = ctl_c_reg;
    assign den       = den_c_reg;
    assign neg       = neg_c_reg;
    assign ovf       = ovf_c_reg;
    assign rem       = rem_c_reg;
    assign acc       = acc_c_reg;
    assign sqn       = rem_c_reg[0];
    assign sqr       = '0;

endmodule

`default_nettype wire

FILE: design/cau_step.sv
// one pipeline stage: one quotient bit per lane and, while K < W, one square root step
// depends on cau_pkg
`default_nettype none

module cau_step #(
    parameter int W = 16,
    parameter int F = 8,
    parameter int K = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 up_ld,
    input  logic                 down_ld,
    output logic                 out_valid,
    input  cau_pkg::ctl_t        ctl_in,
    input  logic [2*W-1:0]       den_in,
    input  logic [1:0]           neg_in,
    input  logic [1:0]           ovf_in,
    input  logic [1:0][2*W-1:0]  rem_in,
    input  logic [1:0][W+F:0]    acc_in,
    input  logic [2*W-1:0]       sqn_in,
    input  logic [2*W-1:0]       sqr_in,
    output cau_pkg::ctl_t        ctl_out,
    output logic [2*W-1:0]       den_out,
    output logic [1:0]           neg_out,
    output logic [1:0]           ovf_out,
    output logic [1:0][2*W-1:0]  rem_out,
    output logic [1:0][W+F:0]    acc_out,
    output logic [2*W-1:0]       sqn_out,
    output logic [2*W-1:0]       sqr_out
);
    import cau_pkg::*;

    localparam int QB = W + F + 1;
    localparam bit SQ_ON = (K < W);
    localparam int SH = SQ_ON ? 2 * (W - 1 - K) : 0;
    localparam logic [2*W-1:0] SQ_BIT = (2*W)'(1) << SH;

    logic                valid_reg;
    ctl_t                ctl_reg;
    logic [2*W-1:0]      den_reg;
    logic [1:0]          neg_reg, ovf_reg;
    logic [1:0][2*W-1:0] rem_reg, rem_next;
    logic [1:0][QB-1:0]  acc_reg, acc_next;
    logic [2*W-1:0]      sqn_reg, sqn_next, sqr_reg, sqr_next;

    assign up_ld = !valid_reg || down_ld;

    always_comb
    begin
        logic [1:0][2*W:0] trial;
        logic [1:0][2*W:0] diff;
        logic [2*W-1:0]    sq_sum;
        rem_next = rem_in;
        acc_next = acc_in;
        for (int l = 0; l < 2; l++)
        begin
            // restoring step: shift the next dividend bit into the remainder
            trial[l] = {rem_in[l], acc_in[l][QB-1]};
            diff[l]  = trial[l] - {1'b0, den_in};
            if (ctl_in.op == OP_DIV && !ovf_in[l])
            begin
                if (!diff[l][2*W])
                begin
                    rem_next[l] = diff[l][2*W-1:0];
                    acc_next[l] = {acc_in[l][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = trial[l][2*W-1:0];
                    acc_next[l] = {acc_in[l][QB-2:0], 1'b0};
                end
            end
        end
        sq_sum   = sqr_in + SQ_BIT;
        sqn_next = sqn_in;
        sqr_next = sqr_in;
        if (SQ_ON && ctl_in.op == OP_MOD)
        begin
            if (sqn_in >= sq_sum)
            begin
                sqn_next = sqn_in - sq_sum;
                sqr_next = (sqr_in >> 1) + SQ_BIT;
            end
            else
                sqr_next = sqr_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ld)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ld)
        begin
            ctl_reg <= ctl_in;
            den_reg <= den_in;
            neg_reg <= neg_in;
            ovf_reg <= ovf_in;
            rem_reg <= rem_next;
            acc_reg <= acc_next;
            sqn_reg <= sqn_next;
            sqr_reg <= sqr_next;
        end
    end

    assign out_valid = valid_reg;
    assign ctl_out   = ctl_reg;
    assign den_out   = den_reg;
    assign neg_out   = neg_reg;
    assign ovf_out   = ovf_reg;
    assign rem_out   = rem_reg;
    assign acc_out   = acc_reg;
    assign sqn_out   = sqn_reg;
    assign sqr_out   = sqr_reg;

endmodule

`default_nettype wire

FILE: design/cau_back.sv
// last two stages: rounding, then saturation into the output register
// depends on cau_pkg
`default_nettype none

module cau_back #(
    parameter int W = 16,
    parameter int F = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 up_ld,
    input  logic                 down_ld,
    output logic                 out_valid,
    input  cau_pkg::ctl_t        ctl_in,
    input  logic [1:0]           neg_in,
    input  logic [1:0]           ovf_in,
    input  logic [1:0][2*W-1:0]  rem_in,
    input  logic [1:0][W+F:0]    acc_in,
    input  logic [2*W-1:0]       sqn_in,
    input  logic [2*W-1:0]       sqr_in,
    output logic [W-1:0]         res_r,
    output logic [W-1:0]         res_i,
    output logic                 sat,
    output logic                 dz
);
    import cau_pkg::*;

    localparam int QB = W + F + 1;
    localparam int RW = ((2 * W > QB) ? 2 * W : QB) + 1;
    localparam logic [RW-1:0] HALF    = (RW'(1) << F) >> 1;
    localparam logic [RW-1:0] POS_MAX = (RW'(1) << (W - 1)) - RW'(1);
    localparam logic [RW-1:0] NEG_LIM = RW'(1) << (W - 1);
    localparam logic [RW-1:0] BIG     = NEG_LIM + RW'(2);
    localparam logic [W-1:0]  S_MAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  S_MIN   = {1'b1, {(W-1){1'b0}}};

    logic [1:0]          valid_reg;
    logic [1:0]          ld;
    logic [1:0][RW-1:0]  mag_reg, mag_next;
    logic [1:0]          neg_reg;
    logic                dz_reg;
    logic [1:0][W-1:0]   res_reg, res_next;
    logic                sat_reg, sat_next, dz_out_reg;

    assign ld[1] = !valid_reg[1] || down_ld;
    assign ld[0] = !valid_reg[0] || ld[1];
    assign up_ld = ld[0];

    always_comb
    begin
        mag_next = '0;
        case (ctl_in.op)
            OP_ADD, OP_SUB:
            begin
                mag_next[0] = RW'(rem_in[0]);
                mag_next[1] = RW'(rem_in[1]);
            end
            OP_MUL:
            begin
                mag_next[0] = (RW'(rem_in[0]) + HALF) >> F;
                mag_next[1] = (RW'(rem_in[1]) + HALF) >> F;
            end
            OP_DIV:
            begin
                mag_next[0] = ovf_in[0] ? BIG : (RW'(acc_in[0]) + RW'(1)) >> 1;
                mag_next[1] = ovf_in[1] ? BIG : (RW'(acc_in[1]) + RW'(1)) >> 1;
            end
            OP_MOD:
                // round to nearest: remainder above the root means bump
                mag_next[0] = RW'(sqr_in) + RW'(sqn_in > sqr_in);
            default:
                mag_next = '0;
        endcase
    end

    always_comb
    begin
        logic [RW-1:0] neg_mag;
        sat_next = 1'b0;
        res_next = '0;
        for (int l = 0; l < 2; l++)
        begin
            neg_mag = RW'(0) - mag_reg[l];
            if (neg_reg[l])
            begin
                if (mag_reg[l] > NEG_LIM)
                begin
                    res_next[l] = S_MIN;
                    sat_next    = 1'b1;
                end
                else
                    res_next[l] = neg_mag[W-1:0];
            end
            else if (mag_reg[l] > POS_MAX)
            begin
                res_next[l] = S_MAX;
                sat_next    = 1'b1;
            end
            else
                res_next[l] = mag_reg[l][W-1:0];
        end
        if (dz_reg)
        begin
            res_next = '0;
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (ld[0])
                valid_reg[0] <= in_valid;
            if (ld[1])
                valid_reg[1] <= valid_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            mag_reg <= mag_next;
            neg_reg <= neg_in;
            dz_reg  <= ctl_in.dz;
        end
        if (ld[1])
        begin
            res_reg    <= res_next;
            sat_reg    <= sat_next;
            dz_out_reg <= dz_reg;
        end
    end

    assign out_valid = valid_reg[1];
    assign res_r     = res_reg[0];
    assign res_i     = res_reg[1];
    assign sat       = sat_reg;
    assign dz        = dz_out_reg;

endmodule

`default_nettype wire

FILE: design/complex_arithmetic_unit_top.sv
// complex arithmetic unit, Q8.8 by default; its pipeline is mostly the
// restoring divider, which resolves one quotient bit per stage; the square
// root shares those stages
// throughput one word per cycle; a full pipeline holds while out_stall is high
// reset clears only the valid bits; no state is kept between words
// depends on cau_pkg, cau_mult, cau_prep, cau_step, cau_back
`default_nettype none

module complex_arithmetic_unit_top #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   req_type,
    input  logic signed [DATA_WIDTH-1:0] a_real,
    input  logic signed [DATA_WIDTH-1:0] a_imag,
    input  logic signed [DATA_WIDTH-1:0] b_real,
    input  logic signed [DATA_WIDTH-1:0] b_imag,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] res_real,
    output logic signed [DATA_WIDTH-1:0] res_imag,
    output logic                         saturated,
    output logic                         div_by_zero
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int QB = W + F + 1;
    localparam logic [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};

    logic                  mult_ld, mult_v, prep_ld, back_ld;
    ctl_t                  mult_ctl;
    logic signed [2*W-1:0] m1, m2, m3, m4, m5, m6;
    logic signed [W:0]     sum_r, sum_i;

    logic [QB:0]                 v_s, ld_s;
    ctl_t [QB:0]                 ctl_s;
    logic [QB:0][2*W-1:0]        den_s, sqn_s, sqr_s;
    logic [QB:0][1:0]            neg_s, ovf_s;
    logic [QB:0][1:0][2*W-1:0]   rem_s;
    logic [QB:0][1:0][QB-1:0]    acc_s;

    logic [W-1:0] res_r, res_i;

    assign in_stall = !mult_ld;

    cau_mult #(.W(W)) u_mult (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .up_ld(mult_ld), .down_ld(prep_ld), .out_valid(mult_v),
        .op_in(req_type), .ar(a_real), .ai(a_imag), .br(b_real), .bi(b_imag),
        .ctl(mult_ctl), .m1(m1), .m2(m2), .m3(m3), .m4(m4), .m5(m5), .m6(m6),
        .sum_r(sum_r), .sum_i(sum_i)
    );

    cau_prep #(.W(W), .F(F)) u_prep (
        .clk(clk), .rst_n(rst_n),
        .in_valid(mult_v), .up_ld(prep_ld), .down_ld(ld_s[0]), .out_valid(v_s[0]),
        .ctl_in(mult_ctl), .m1(m1), .m2(m2), .m3(m3), .m4(m4), .m5(m5), .m6(m6),
        .sum_r(sum_r), .sum_i(sum_i),
        .ctl_out(ctl_s[0]), .den(den_s[0]), .neg(neg_s[0]), .ovf(ovf_s[0]),
        .rem(rem_s[0]), .acc(acc_s[0]), .sqn(sqn_s[0]), .sqr(sqr_s[0])
    );

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        cau_step #(.W(W), .F(F), .K(k)) u_step (
            .clk(clk), .rst_n(rst_n),
            .in_valid(v_s[k]), .up_ld(ld_s[k]), .down_ld(ld_s[k+1]),
            .out_valid(v_s[k+1]),
            .ctl_in(ctl_s[k]), .den_in(den_s[k]), .neg_in(neg_s[k]), .ovf_in(ovf_s[k]),
            .rem_in(rem_s[k]), .acc_in(acc_s[k]), .sqn_in(sqn_s[k]), .sqr_in(sqr_s[k]),
            .ctl_out(ctl_s[k+1]), .den_out(den_s[k+1]), .neg_out(neg_s[k+1]),
            .ovf_out(ovf_s[k+1]), .rem_out(rem_s[k+1]), .acc_out(acc_s[k+1]),
            .sqn_out(sqn_s[k+1]), .sqr_out(sqr_s[k+1])
        );
    end

    assign ld_s[QB] = back_ld;

    cau_back #(.W(W), .F(F)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(v_s[QB]), .up_ld(back_ld), .down_ld(!out_valid || !out_stall),
        .out_valid(out_valid),
        .ctl_in(ctl_s[QB]), .neg_in(neg_s[QB]), .ovf_in(ovf_s[QB]),
        .rem_in(rem_s[QB]), .acc_in(acc_s[QB]), .sqn_in(sqn_s[QB]), .sqr_in(sqr_s[QB]),
        .res_r(res_r), .res_i(res_i), .sat(saturated), .dz(div_by_zero)
    );

    assign res_real = res_r;
    assign res_imag = res_i;

    // the input side only backs up when the whole pipe is full and blocked
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with room in the pipeline");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && div_by_zero) |-> (res_r == '0 && res_i == '0 && !saturated))
        else $error("zero divisor word carries a nonzero result");

    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
        (res_r == S_MAX || res_r == S_MIN || res_i == S_MAX || res_i == S_MIN))
        else $error("saturation flag without a clipped part");

endmodule

`default_nettype wire
